FILE: hdl/x86_logic_shift_alu_macros.svh
// Assertion macros shared by the x86 logic and shift unit.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef X86_LOGIC_SHIFT_ALU_MACROS_SVH
`define X86_LOGIC_SHIFT_ALU_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define XLSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define XLSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/xlsa_pkg.sv
// Package for the x86 logic and shift unit: operation, size and condition codes,
// and the request and result structures shared by the datapath and the top level.
// No dependencies.
package xlsa_pkg;

  typedef enum logic [3:0] {
    MODE_TEST  = 4'd0,
    MODE_AND   = 4'd1,
    MODE_XOR   = 4'd2,
    MODE_OR    = 4'd3,
    MODE_SAR   = 4'd4,
    MODE_SHL   = 4'd5,
    MODE_SHR   = 4'd6,
    MODE_SETCC = 4'd7,
    MODE_NOT   = 4'd8,
    MODE_ROL   = 4'd9,
    MODE_SHLD  = 4'd10,
    MODE_SHRD  = 4'd11
  } xlsa_mode_t;

  typedef enum logic [1:0] {
    SIZE_8  = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_32 = 2'd2
  } xlsa_size_t;

  // Condition groups: the condition code without its invert bit.
  typedef enum logic [2:0] {
    COND_O  = 3'd0,
    COND_B  = 3'd1,
    COND_Z  = 3'd2,
    COND_BE = 3'd3,
    COND_S  = 3'd4,
    COND_P  = 3'd5,
    COND_L  = 3'd6,
    COND_LE = 3'd7
  } xlsa_cond_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [1:0]  size_code;
    logic [31:0] dest_value;
    logic [31:0] src_value;
    logic [7:0]  double_count;
    logic [3:0]  cond_code;
    logic        carry_in;
    logic        overflow_in;
    logic        zero_in;
    logic        sign_in;
  } xlsa_req_t;

  typedef struct packed {
    logic [31:0] result;
    logic        write_result;
    logic        carry_out;
    logic        overflow_out;
    logic        zero_out;
    logic        sign_out;
  } xlsa_res_t;

endpackage

FILE: hdl/xlsa_exec.sv
// Combinational datapath of the x86 logic and shift unit: logic ops, shifters,
// rotate, double shifts, condition evaluation and flag generation.
// Depends on xlsa_pkg.
module xlsa_exec
  import xlsa_pkg::*;
(
  input  xlsa_req_t req,
  output xlsa_res_t res
);

  logic [31:0] mask;
  logic [4:0]  top_idx;
  logic [4:0]  rot_kmask;
  logic [31:0] d;
  logic [31:0] s;
  logic [4:0]  cnt;
  logic [4:0]  dcnt;
  logic [31:0] ext;
  logic [63:0] rep;
  logic [63:0] rot_wide;
  logic [63:0] cat_l;
  logic [63:0] cat_r;
  logic [63:0] shl_wide;
  logic [63:0] shr_wide;
  logic [31:0] shld_r;
  logic        base;
  logic        cond_ok;
  logic [31:0] r;
  logic        wr;
  logic        cf;
  logic        of;
  logic        zf;
  logic        sf;
  logic        zs;

  always_comb begin
    case (req.size_code)
      SIZE_8: begin
        mask      = 32'h0000_00ff;
        top_idx   = 5'd7;
        rot_kmask = 5'd7;
      end
      SIZE_16: begin
        mask      = 32'h0000_ffff;
        top_idx   = 5'd15;
        rot_kmask = 5'd15;
      end
      default: begin
        mask      = 32'hffff_ffff;
        top_idx   = 5'd31;
        rot_kmask = 5'd31;
      end
    endcase

    d    = req.dest_value & mask;
    s    = req.src_value & mask;
    cnt  = req.src_value[4:0];
    dcnt = req.double_count[4:0];

    // Size-dependent operand views for the arithmetic shift, rotate and double shifts.
    case (req.size_code)
      SIZE_8: begin
        ext    = {{24{d[7]}}, d[7:0]};
        rep    = {8{d[7:0]}};
        cat_l  = {48'd0, d[7:0], s[7:0]};
        cat_r  = {48'd0, s[7:0], d[7:0]};
      end
      SIZE_16: begin
        ext    = {{16{d[15]}}, d[15:0]};
        rep    = {4{d[15:0]}};
        cat_l  = {32'd0, d[15:0], s[15:0]};
        cat_r  = {32'd0, s[15:0], d[15:0]};
      end
      default: begin
        ext    = d;
        rep    = {2{d}};
        cat_l  = {d, s};
        cat_r  = {s, d};
      end
    endcase

    // The replicated operand has period n, so the upper half of the shifted
    // word is the n-bit left rotate repeated.
    rot_wide = rep << (cnt & rot_kmask);
    shl_wide = cat_l << dcnt;
    shr_wide = cat_r >> dcnt;

    case (req.size_code)
      SIZE_8:  shld_r = {24'd0, shl_wide[15:8]};
      SIZE_16: shld_r = {16'd0, shl_wide[31:16]};
      default: shld_r = shl_wide[63:32];
    endcase

    case (req.cond_code[3:1])
      COND_O:  base = req.overflow_in;
      COND_B:  base = req.carry_in;
      COND_Z:  base = req.zero_in;
      COND_BE: base = req.carry_in | req.zero_in;
      COND_S:  base = req.sign_in;
      COND_P:  base = 1'b0;
      COND_L:  base = req.sign_in ^ req.overflow_in;
      default: base = req.zero_in | (req.sign_in ^ req.overflow_in);
    endcase
    // Parity is not tracked, so both parity conditions report false.
    if (req.cond_code[3:1] == COND_P) begin
      cond_ok = 1'b0;
    end else begin
      cond_ok = base ^ req.cond_code[0];
    end

    r  = 32'd0;
    wr = 1'b1;
    cf = req.carry_in;
    of = req.overflow_in;
    zf = req.zero_in;
    sf = req.sign_in;
    zs = 1'b0;

    case (req.mode)
      MODE_TEST: begin
        r = d & s; wr = 1'b0; cf = 1'b0; of = 1'b0; zs = 1'b1;
      end
      MODE_AND: begin
        r = d & s; cf = 1'b0; of = 1'b0; zs = 1'b1;
      end
      MODE_XOR: begin
        r = d ^ s; cf = 1'b0; of = 1'b0; zs = 1'b1;
      end
      MODE_OR: begin
        r = d | s; cf = 1'b0; of = 1'b0; zs = 1'b1;
      end
      MODE_SAR: begin
        r  = 32'($signed(ext) >>> cnt) & mask;
        zs = 1'b1;
      end
      MODE_SHL: begin
        r  = (d << cnt) & mask;
        zs = 1'b1;
      end
      MODE_SHR: begin
        r  = d >> cnt;
        zs = 1'b1;
      end
      MODE_SETCC: begin
        r = {31'd0, cond_ok};
      end
      MODE_NOT: begin
        r = ~d & mask;
      end
      MODE_ROL: begin
        r = rot_wide[63:32] & mask;
        if (cnt != 5'd0) begin
          cf = r[0];
          of = r[top_idx] ^ r[0];
        end
      end
      MODE_SHLD: begin
        r  = shld_r;
        zs = (dcnt != 5'd0);
      end
      MODE_SHRD: begin
        r  = shr_wide[31:0] & mask;
        zs = (dcnt != 5'd0);
      end
      default: begin
        r  = 32'd0;
        wr = 1'b0;
      end
    endcase

    if (zs) begin
      zf = (r == 32'd0);
      sf = r[top_idx];
    end

    res.result       = r;
    res.write_result = wr;
    res.carry_out    = cf;
    res.overflow_out = of;
    res.zero_out     = zf;
    res.sign_out     = sf;
  end

endmodule

FILE: hdl/x86_logic_shift_alu.sv
// Top level of the x86 logic and shift unit: input register, datapath and
// result register with stream handshakes. Depends on xlsa_pkg, xlsa_exec and
// x86_logic_shift_alu_macros.svh.

// This unit executes one x86 logic, shift, rotate, double-shift, NOT or SETcc
// request per cycle while the consumer keeps up. Each request is captured in an
// input register, evaluated in a single combinational pass (mask to operand
// size, 64-bit barrel shifters and the flag logic) and stored in a result
// register, from which it is presented on the output; a new request can be
// accepted in every cycle while the consumer does not stall, so sustained
// throughput is one request per clock, bounded only by the single-pass datapath
// between those two registers. When the consumer stalls, both registers hold and
// s_axis_tready falls only once both are occupied, so no request is lost or
// repeated. Flags an operation does not change are passed through from the
// incoming flags, and unused operation codes return zero with no write.
module x86_logic_shift_alu
  import xlsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // From bit 0 up: mode[3:0], size_code[5:4], dest_value[37:6], src_value[69:38],
  // double_count[77:70], cond_code[81:78], carry_in[82], overflow_in[83],
  // zero_in[84], sign_in[85], zero pad[87:86].
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // From bit 0 up: result[31:0], write_result[32], carry_out[33],
  // overflow_out[34], zero_out[35], sign_out[36], zero pad[39:37].
  output logic [39:0] m_axis_tdata
);

  // Input register stage.
  logic      in_valid;
  xlsa_req_t in_req;

  // Result register stage.
  logic      out_valid;
  xlsa_res_t out_res;

  xlsa_res_t exec_res;
  logic      out_free;
  logic      in_take;

  // The result register can load when it is empty or being drained this cycle.
  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // Payload needs no reset; it is qualified by in_valid.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req.mode         <= s_axis_tdata[3:0];
      in_req.size_code    <= s_axis_tdata[5:4];
      in_req.dest_value   <= s_axis_tdata[37:6];
      in_req.src_value    <= s_axis_tdata[69:38];
      in_req.double_count <= s_axis_tdata[77:70];
      in_req.cond_code    <= s_axis_tdata[81:78];
      in_req.carry_in     <= s_axis_tdata[82];
      in_req.overflow_in  <= s_axis_tdata[83];
      in_req.zero_in      <= s_axis_tdata[84];
      in_req.sign_in      <= s_axis_tdata[85];
    end
  end

  xlsa_exec u_exec (
    .req (in_req),
    .res (exec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid) begin
      out_res <= exec_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0, out_res.sign_out, out_res.zero_out, out_res.overflow_out,
                          out_res.carry_out, out_res.write_result, out_res.result};

`include "x86_logic_shift_alu_macros.svh"

  // A request in the input stage moves to the result stage whenever that stage is free.
  `XLSA_ASSERT_NEXT(a_advance, in_valid && out_free, m_axis_tvalid, "request not advanced")

  // Backpressure reaches the input only when both stages are full and stalled.
  `XLSA_ASSERT_NOW(a_ready_low, !s_axis_tready,
                   in_valid && m_axis_tvalid && !m_axis_tready, "spurious input stall")

  // TEST never writes its destination.
  `XLSA_ASSERT_NEXT(a_test_nowrite, in_valid && out_free && (in_req.mode == MODE_TEST),
                    !m_axis_tdata[32], "test wrote destination")

  // A byte-sized operation leaves the upper result bits clear.
  `XLSA_ASSERT_NEXT(a_byte_mask, in_valid && out_free && (in_req.size_code == SIZE_8),
                    m_axis_tdata[31:8] == 24'd0, "byte result not masked")

endmodule

FILE: tb/tb_x86_logic_shift_alu.sv
// Self-checking testbench for the x86 logic and shift unit: directed and random requests,
// random stalls on both stream sides, predicted results checked in order.
// Depends on xlsa_pkg and x86_logic_shift_alu.
`timescale 1ns / 1ps

module tb_x86_logic_shift_alu
  import xlsa_pkg::*;
();

  // Operation codes 12 to 15 are not assigned; the unit answers them with zero and no write.
  localparam logic [3:0] MODE_UNUSED_LO = 4'd12;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;
  // Size code three is not named by the package and must behave as a 32-bit operand.
  localparam logic [1:0] SIZE_32_ALIAS  = 2'd3;
  // Cycles the receiver holds off during the back-pressure test.
  localparam int LONG_HOLD_CYCLES = 120;
  // Cycles allowed after the last result so that a stray extra result is still seen.
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  // Shared between the stimulus process and the receiver process.
  bit rx_idle_on;
  bit long_hold_req;

  // Holds the predicted result of every accepted request until the unit returns it.
  class alu_scoreboard;
    xlsa_res_t alu_results_due[$];
    int        mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Computes what the unit must return for one request.
    function xlsa_res_t predict_alu(xlsa_req_t q);
      int unsigned width;
      int unsigned k;
      logic [31:0] mask, d, s, r, ext;
      logic [63:0] joined;
      logic [4:0]  cnt, dcnt;
      logic        cf, of, zf, sf, wr, sets_zs, holds;
      xlsa_cond_t  grp;
      xlsa_res_t   o;
      case (q.size_code)
        SIZE_8:  width = 8;
        SIZE_16: width = 16;
        default: width = 32;
      endcase
      mask    = (width == 32) ? 32'hffff_ffff : ((32'd1 << width) - 32'd1);
      d       = q.dest_value & mask;
      s       = q.src_value & mask;
      cnt     = q.src_value[4:0];
      dcnt    = q.double_count[4:0];
      cf      = q.carry_in;
      of      = q.overflow_in;
      zf      = q.zero_in;
      sf      = q.sign_in;
      r       = '0;
      wr      = 1'b1;
      sets_zs = 1'b0;
      holds   = 1'b0;
      case (q.mode)
        MODE_TEST: begin
          r = d & s; wr = 1'b0; cf = 1'b0; of = 1'b0; sets_zs = 1'b1;
        end
        MODE_AND: begin
          r = d & s; cf = 1'b0; of = 1'b0; sets_zs = 1'b1;
        end
        MODE_XOR: begin
          r = d ^ s; cf = 1'b0; of = 1'b0; sets_zs = 1'b1;
        end
        MODE_OR: begin
          r = d | s; cf = 1'b0; of = 1'b0; sets_zs = 1'b1;
        end
        MODE_SAR: begin
          // Sign-extend to 32 bits, then an arithmetic shift keeps the sign fill.
          ext = d[width-1] ? (d | ~mask) : d;
          ext = $signed(ext) >>> cnt;
          r = ext & mask;
          sets_zs = 1'b1;
        end
        MODE_SHL: begin
          r = (d << cnt) & mask; sets_zs = 1'b1;
        end
        MODE_SHR: begin
          r = d >> cnt; sets_zs = 1'b1;
        end
        MODE_SETCC: begin
          grp = xlsa_cond_t'(q.cond_code[3:1]);
          case (grp)
            COND_O:  holds = of;
            COND_B:  holds = cf;
            COND_Z:  holds = zf;
            COND_BE: holds = cf | zf;
            COND_S:  holds = sf;
            COND_P:  holds = 1'b0;
            COND_L:  holds = sf ^ of;
            default: holds = zf | (sf ^ of);
          endcase
          // Parity is not tracked, so both parity conditions read as false.
          r = (grp == COND_P) ? 32'd0 : {31'd0, holds ^ q.cond_code[0]};
        end
        MODE_NOT: begin
          r = ~d & mask;
        end
        MODE_ROL: begin
          k = cnt % width;
          r = (k == 0) ? d : (((d << k) | (d >> (width - k))) & mask);
          // A count that is a multiple of the size still updates the flags unless it is zero.
          if (cnt != 5'd0) begin
            cf = r[0];
            of = r[width-1] ^ r[0];
          end
        end
        MODE_SHLD: begin
          joined  = ({32'd0, d} << width) | {32'd0, s};
          joined  = (joined << dcnt) >> width;
          r       = joined[31:0] & mask;
          sets_zs = (dcnt != 5'd0);
        end
        MODE_SHRD: begin
          joined  = ({32'd0, s} << width) | {32'd0, d};
          joined  = joined >> dcnt;
          r       = joined[31:0] & mask;
          sets_zs = (dcnt != 5'd0);
        end
        default: begin
          r = '0; wr = 1'b0;
        end
      endcase
      if (sets_zs) begin
        zf = (r == 32'd0);
        sf = r[width-1];
      end
      o.result       = r & mask;
      o.write_result = wr;
      o.carry_out    = cf;
      o.overflow_out = of;
      o.zero_out     = zf;
      o.sign_out     = sf;
      return o;
    endfunction

    function void note_request(xlsa_req_t q);
      alu_results_due.push_back(predict_alu(q));
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
        mismatch_count++;
      end
    endfunction

    function void check_result(xlsa_res_t got);
      xlsa_res_t want;
      if (alu_results_due.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
        mismatch_count++;
        return;
      end
      want = alu_results_due.pop_front();
      compare_field("result", want.result, got.result);
      compare_field("write_result", 32'(want.write_result), 32'(got.write_result));
      compare_field("carry_out", 32'(want.carry_out), 32'(got.carry_out));
      compare_field("overflow_out", 32'(want.overflow_out), 32'(got.overflow_out));
      compare_field("zero_out", 32'(want.zero_out), 32'(got.zero_out));
      compare_field("sign_out", 32'(want.sign_out), 32'(got.sign_out));
    endfunction
  endclass

  alu_scoreboard sb = new();

  x86_logic_shift_alu u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 ns clock period.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // The request bus carries the mode in its lowest bits and the flags at the top,
  // so the package structure, which is packed the other way round, is reordered here.
  function automatic logic [87:0] pack_request(xlsa_req_t q);
    return {2'b00, q.sign_in, q.zero_in, q.overflow_in, q.carry_in, q.cond_code,
            q.double_count, q.src_value, q.dest_value, q.size_code, q.mode};
  endfunction

  function automatic xlsa_req_t unpack_request(logic [87:0] t);
    xlsa_req_t q;
    q.mode         = t[3:0];
    q.size_code    = t[5:4];
    q.dest_value   = t[37:6];
    q.src_value    = t[69:38];
    q.double_count = t[77:70];
    q.cond_code    = t[81:78];
    q.carry_in     = t[82];
    q.overflow_in  = t[83];
    q.zero_in      = t[84];
    q.sign_in      = t[85];
    return q;
  endfunction

  function automatic xlsa_res_t unpack_result(logic [39:0] t);
    xlsa_res_t o;
    o.result       = t[31:0];
    o.write_result = t[32];
    o.carry_out    = t[33];
    o.overflow_out = t[34];
    o.zero_out     = t[35];
    o.sign_out     = t[36];
    return o;
  endfunction

  // Both handshakes are observed at the rising edge. All inputs change at the falling
  // edge, so the values seen here are stable. The request is noted before the result
  // is checked, which keeps the order right even for a very short latency.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(unpack_request(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) sb.check_result(unpack_result(m_axis_tdata));
    end
  end

  // Builds a request from its fields; the flags come packed as {sign, zero, overflow, carry}.
  function automatic xlsa_req_t make_request(logic [3:0] mode, logic [1:0] size_code,
                                             logic [31:0] dest_value, logic [31:0] src_value,
                                             logic [7:0] double_count, logic [3:0] cond_code,
                                             logic [3:0] flags);
    xlsa_req_t q;
    q.mode         = mode;
    q.size_code    = size_code;
    q.dest_value   = dest_value;
    q.src_value    = src_value;
    q.double_count = double_count;
    q.cond_code    = cond_code;
    q.carry_in     = flags[0];
    q.overflow_in  = flags[1];
    q.zero_in      = flags[2];
    q.sign_in      = flags[3];
    return q;
  endfunction

  // Operand values lean toward the corners: zero, all ones, single bits, sign bits.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = 32'd0;
      1:       v = 32'hffff_ffff;
      2:       v = 32'd1 << $urandom_range(0, 31);
      3:       v = ~(32'd1 << $urandom_range(0, 31));
      4:       v = 32'h0000_0080 << (8 * $urandom_range(0, 3));
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Offers one request at a falling edge and returns at the falling edge after it was
  // accepted. tvalid stays high between back-to-back calls.
  task automatic send_request(input xlsa_req_t q);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_request(q);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends random requests; with idling on, the sender drops tvalid before about one request in six.
  task automatic send_random_requests(input int count, input bit idle_on);
    xlsa_req_t q;
    for (int i = 0; i < count; i++) begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      // One request in twenty uses an unassigned operation code.
      if ($urandom_range(0, 19) == 0) q.mode = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      else q.mode = 4'($urandom_range(MODE_TEST, MODE_SHRD));
      q.size_code    = 2'($urandom_range(0, 3));
      q.dest_value   = pick_operand();
      q.src_value    = pick_operand();
      q.double_count = 8'($urandom_range(0, 255));
      q.cond_code    = 4'($urandom_range(0, 15));
      q.carry_in     = 1'($urandom_range(0, 1));
      q.overflow_in  = 1'($urandom_range(0, 1));
      q.zero_in      = 1'($urandom_range(0, 1));
      q.sign_in      = 1'($urandom_range(0, 1));
      send_request(q);
    end
  endtask

  task automatic wait_results_drained();
    while (sb.alu_results_due.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, and on request one long hold-off counted here so that
  // both pipeline registers fill and the unit drops s_axis_tready.
  initial begin : receiver
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rx_idle_on    = 1'b1;
    long_hold_req = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests: each operation, the operand extremes and the corner cases.
    // Logic operations with full and empty operands, including size code three.
    send_request(make_request(MODE_TEST, SIZE_32, 32'hffff_ffff, 32'hffff_ffff, 8'd0, 4'd0,
                              4'hf));
    send_request(make_request(MODE_AND, SIZE_8, 32'hffff_ff00, 32'h0000_00ff, 8'd0, 4'd0,
                              4'hf));
    send_request(make_request(MODE_XOR, SIZE_16, 32'h1234_8001, 32'hffff_0001, 8'd0, 4'd0,
                              4'h3));
    send_request(make_request(MODE_OR, SIZE_32_ALIAS, 32'h8000_0000, 32'h0000_0001, 8'd0,
                              4'd0, 4'h0));
    // Arithmetic right shifts of a negative value, up to the largest count.
    send_request(make_request(MODE_SAR, SIZE_8, 32'h0000_0080, 32'd7, 8'd0, 4'd0, 4'h0));
    send_request(make_request(MODE_SAR, SIZE_32, 32'h8000_0000, 32'hffff_ffff, 8'd0, 4'd0,
                              4'h5));
    // A zero-count shift still refreshes ZF and SF.
    send_request(make_request(MODE_SHL, SIZE_16, 32'h0000_8000, 32'h0000_0020, 8'd0, 4'd0,
                              4'h4));
    send_request(make_request(MODE_SHR, SIZE_32, 32'hffff_ffff, 32'd31, 8'd0, 4'd0, 4'hf));
    // Parity conditions read as false in both senses; the others follow the flags.
    send_request(make_request(MODE_SETCC, SIZE_8, 32'd0, 32'd0, 8'd0, {COND_P, 1'b0}, 4'hf));
    send_request(make_request(MODE_SETCC, SIZE_8, 32'd0, 32'd0, 8'd0, {COND_P, 1'b1}, 4'h0));
    send_request(make_request(MODE_SETCC, SIZE_32, 32'hffff_ffff, 32'd0, 8'd0,
                              {COND_LE, 1'b1}, 4'h0));
    send_request(make_request(MODE_SETCC, SIZE_16, 32'd0, 32'd0, 8'd0, {COND_Z, 1'b0}, 4'h4));
    send_request(make_request(MODE_NOT, SIZE_8, 32'h1234_565a, 32'd0, 8'd0, 4'd0, 4'ha));
    // Rotates: a zero count keeps the flags, a count equal to the size does not.
    send_request(make_request(MODE_ROL, SIZE_32, 32'h8000_0001, 32'h0000_0020, 8'd0, 4'd0,
                              4'hf));
    send_request(make_request(MODE_ROL, SIZE_8, 32'h0000_0081, 32'd8, 8'd0, 4'd0, 4'h0));
    send_request(make_request(MODE_ROL, SIZE_16, 32'h0000_c001, 32'd31, 8'd0, 4'd0, 4'h0));
    // Double shifts: zero count, counts beyond the operand size and the byte size.
    send_request(make_request(MODE_SHLD, SIZE_32, 32'h0000_0000, 32'hffff_ffff, 8'd0, 4'd0,
                              4'h6));
    send_request(make_request(MODE_SHLD, SIZE_8, 32'h0000_00a5, 32'h0000_003c, 8'd20, 4'd0,
                              4'h0));
    send_request(make_request(MODE_SHLD, SIZE_16, 32'h0000_8001, 32'h0000_ffff, 8'd255,
                              4'd0, 4'h9));
    send_request(make_request(MODE_SHRD, SIZE_32, 32'h0000_0001, 32'h8000_0000, 8'd31, 4'd0,
                              4'h0));
    send_request(make_request(MODE_SHRD, SIZE_8, 32'h0000_00ff, 32'h0000_0081, 8'd17, 4'd0,
                              4'hf));
    send_request(make_request(MODE_SHRD, SIZE_32_ALIAS, 32'hffff_fffe, 32'h0000_0001, 8'd1,
                              4'd0, 4'h0));
    // Unassigned operation codes return zero, no write and the incoming flags.
    send_request(make_request(MODE_UNUSED_LO, SIZE_16, 32'hffff_ffff, 32'hffff_ffff, 8'd255,
                              4'hf, 4'hf));
    send_request(make_request(MODE_UNUSED_HI, SIZE_32_ALIAS, 32'h8000_0000, 32'd1, 8'd1,
                              4'h0, 4'h5));

    send_random_requests(400, 1'b1);

    // Sender pause: nothing is offered until every outstanding result has come back.
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    wait_results_drained();

    // Back-pressure: the receiver holds off while the sender keeps offering without gaps.
    long_hold_req = 1'b1;
    send_random_requests(80, 1'b0);
    send_random_requests(550, 1'b1);

    // Last stretch at full rate on both sides.
    rx_idle_on = 1'b0;
    send_random_requests(220, 1'b0);

    s_axis_tvalid <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.mismatch_count == 0 && sb.alu_results_due.size() == 0) begin
      $display("PASS x86_logic_shift_alu");
    end else begin
      $display("FAIL x86_logic_shift_alu");
    end
    $finish;
  end

  // Watchdog: 10 ms is many times the slowest legal run of this sequence.
  initial begin : watchdog
    #10_000_000;
    $display("FAIL x86_logic_shift_alu");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/xlsa_pkg.sv
hdl/xlsa_exec.sv
hdl/x86_logic_shift_alu.sv
tb/tb_x86_logic_shift_alu.sv
